// ----- src/blrm_pkg.sv -----
// types and codes shared by the block range map files
`timescale 1ns / 1ps
package blrm_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_RANGE    = 3'd1,
		ST_OVERLAP      = 3'd2,
		ST_PAST_32      = 3'd3,
		ST_FULL         = 3'd4,
		ST_NOT_FINISHED = 3'd5
	} status_t;

	typedef struct packed {
		logic [63:0] first;
		logic [63:0] last;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KEY,
		S_KEYW,
		S_CMP,
		S_PUT,
		S_CHK_START,
		S_CHK,
		S_Q_SRCH,
		S_Q_CMP,
		S_Q_LAST,
		S_RESP
	} state_t;

endpackage

// ----- src/blrm_table_ram.sv -----
// range table memory, one write port and one registered read port
`timescale 1ns / 1ps
module blrm_table_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output blrm_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  blrm_pkg::entry_t     wr_data
);
	import blrm_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/block_range_map_lookup.sv -----
// block range map: range table build, sort, validate and lookup
`timescale 1ns / 1ps
// Holds up to MAX_RANGES block ranges in one synchronous table memory
// (first and last block per entry). One beat is taken at a time; each beat
// gives exactly one result beat, held in an output register so the next
// beat can be taken while a result waits. Clear, add, finish of an empty
// table and a query before finish go straight to the response state, from
// which the result is registered once the output slot is free. A query is
// a binary search, one read of the memory read port per probe, then a read
// of the candidate range. Finish runs an in-place insertion sort on the one
// read and one write port when two or more ranges are held, then a
// validation sweep over every entry. The table needs no clearing pass after
// reset: only entries below the range count are ever read.
module block_range_map_lookup #(
	parameter int MAX_RANGES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  blrm_pkg::cmd_t        command,
	input  logic [63:0]           first_block,
	input  logic [63:0]           last_block,
	output logic                  out_valid,
	input  logic                  out_ready,
	output blrm_pkg::status_t     status,
	output logic                  mapped,
	output logic [10:0]           ranges_held
);
	import blrm_pkg::*;

	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          fin_q, fin_d;
	entry_t        key_q, key_d;
	logic [CW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic [63:0]   prev_last_q, prev_last_d;
	logic          ovl_q, ovl_d, past_q, past_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [63:0]   blk_q, blk_d;
	status_t       res_status_q, res_status_d;
	logic          res_mapped_q, res_mapped_d;

	logic          out_valid_q;
	status_t       out_status_q;
	logic          out_mapped_q;
	logic [10:0]   out_count_q;
	logic          out_load;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	entry_t        rd_data, wr_data;

	logic          accept;
	logic          cur_ovl, cur_past;
	logic [CW-1:0] mid_c;

	blrm_table_ram #(.DEPTH(MAX_RANGES), .AW(AW)) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// output slot free or being emptied this cycle
	assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	// overlap and 32-bit tests on the entry returned in the check sweep
	assign cur_ovl  = (k_q != '0) && (rd_data.first <= prev_last_q);
	assign cur_past = (|rd_data.first[63:32]) || (|rd_data.last[63:32]);
	assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		fin_d        = fin_q;
		key_d        = key_q;
		i_d          = i_q;
		j_d          = j_q;
		k_d          = k_q;
		prev_last_d  = prev_last_q;
		ovl_d        = ovl_q;
		past_d       = past_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_d        = mid_q;
		blk_d        = blk_q;
		res_status_d = res_status_q;
		res_mapped_d = res_mapped_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = key_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_status_d = ST_OK;
					res_mapped_d = 1'b0;
					state_d      = S_RESP;
					unique case (command)
						CMD_CLEAR: begin
							count_d = '0;
							fin_d   = 1'b0;
						end
						CMD_ADD: begin
							priority if (first_block > last_block || (&last_block)) begin
								res_status_d = ST_BAD_RANGE;
								count_d      = '0;
								fin_d        = 1'b0;
							end else if (count_q >= CW'(MAX_RANGES)) begin
								res_status_d = ST_FULL;
							end else begin
								wr_en         = 1'b1;
								wr_addr       = count_q[AW-1:0];
								wr_data.first = first_block;
								wr_data.last  = last_block;
								count_d       = count_q + 1'b1;
								fin_d         = 1'b0;
							end
						end
						CMD_FINISH: begin
							priority if (count_q == '0) begin
								fin_d = 1'b1;
							end else if (count_q == CW'(1)) begin
								state_d = S_CHK_START;
							end else begin
								i_d     = CW'(1);
								state_d = S_KEY;
							end
						end
						CMD_QUERY: begin
							if (!fin_q) begin
								res_status_d = ST_NOT_FINISHED;
							end else begin
								blk_d   = first_block;
								lo_d    = '0;
								hi_d    = count_q;
								state_d = S_Q_SRCH;
							end
						end
						default: ;
					endcase
				end
			end
			// insertion sort: fetch key at i
			S_KEY: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
				state_d = S_KEYW;
			end
			S_KEYW: begin
				key_d   = rd_data;
				j_d     = i_q;
				rd_en   = 1'b1;
				rd_addr = AW'(i_q - 1'b1);
				state_d = S_CMP;
			end
			// shift larger entries up one place
			S_CMP: begin
				if (rd_data.first > key_q.first) begin
					wr_en   = 1'b1;
					wr_addr = j_q[AW-1:0];
					wr_data = rd_data;
					j_d     = j_q - 1'b1;
					if (j_q == CW'(1)) begin
						state_d = S_PUT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = AW'(j_q - CW'(2));
					end
				end else begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = key_q;
				i_d     = i_q + 1'b1;
				if (i_q + 1'b1 < count_q) begin
					state_d = S_KEY;
				end else begin
					state_d = S_CHK_START;
				end
			end
			// validation sweep over the sorted table
			S_CHK_START: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				k_d     = '0;
				ovl_d   = 1'b0;
				past_d  = 1'b0;
				state_d = S_CHK;
			end
			S_CHK: begin
				ovl_d       = ovl_q | cur_ovl;
				past_d      = past_q | cur_past;
				prev_last_d = rd_data.last;
				if (k_q + 1'b1 < count_q) begin
					k_d     = k_q + 1'b1;
					rd_en   = 1'b1;
					rd_addr = AW'(k_q + 1'b1);
				end else begin
					state_d = S_RESP;
					priority if (ovl_q || cur_ovl) begin
						res_status_d = ST_OVERLAP;
						count_d      = '0;
						fin_d        = 1'b0;
					end else if (past_q || cur_past) begin
						res_status_d = ST_PAST_32;
						count_d      = '0;
						fin_d        = 1'b0;
					end else begin
						fin_d = 1'b1;
					end
				end
			end
			// binary search for last range starting at or before the block
			S_Q_SRCH: begin
				if (lo_q < hi_q) begin
					mid_d   = mid_c;
					rd_en   = 1'b1;
					rd_addr = mid_c[AW-1:0];
					state_d = S_Q_CMP;
				end else if (lo_q == '0) begin
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(lo_q - 1'b1);
					state_d = S_Q_LAST;
				end
			end
			S_Q_CMP: begin
				if (blk_q < rd_data.first) begin
					hi_d = mid_q;
				end else begin
					lo_d = mid_q + 1'b1;
				end
				state_d = S_Q_SRCH;
			end
			S_Q_LAST: begin
				res_mapped_d = (blk_q <= rd_data.last);
				state_d      = S_RESP;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fin_q   <= fin_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q        <= key_d;
		i_q          <= i_d;
		j_q          <= j_d;
		k_q          <= k_d;
		prev_last_q  <= prev_last_d;
		ovl_q        <= ovl_d;
		past_q       <= past_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		mid_q        <= mid_d;
		blk_q        <= blk_d;
		res_status_q <= res_status_d;
		res_mapped_q <= res_mapped_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_mapped_q <= res_mapped_q;
			out_count_q  <= 11'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign mapped      = out_mapped_q;
	assign ranges_held = out_count_q;

	// range count never exceeds table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RANGES))
		else $error("range count past table depth");

	// table writes only on add or during sort
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IDLE || state_q == S_CMP || state_q == S_PUT))
		else $error("table write outside add or sort");

	// an accepted beat always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted beat did not start work");

	// errors never report a hit
	a_err_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status_q != ST_OK) |=> !out_mapped_q)
		else $error("error result reports mapped");

endmodule

// ----- sim/block_range_map_lookup_tb.sv -----
// testbench for block_range_map_lookup: directed, full table and random range sequences
`timescale 1ns / 1ps
module block_range_map_lookup_tb;
	import blrm_pkg::*;

	localparam int MAX_RANGES = 1024;
	localparam longint unsigned CYCLE_LIMIT = 3000000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;

	// one expected result beat
	typedef struct {
		status_t     st;
		logic        mp;
		logic [10:0] cnt;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	cmd_t        command;
	logic [63:0] first_block;
	logic [63:0] last_block;
	logic        out_valid;
	logic        out_ready;
	status_t     status;
	logic        mapped;
	logic [10:0] ranges_held;

	// predicted table state
	logic [63:0] tbl_first [MAX_RANGES];
	logic [63:0] tbl_last [MAX_RANGES];
	int unsigned tbl_count;
	bit          tbl_done;

	answer_t     pending_answers [$];
	int          errors;
	int          beats_sent;
	int          beats_checked;
	int          queries_hit;
	bit          calm;
	longint unsigned cycles;

	block_range_map_lookup #(.MAX_RANGES(MAX_RANGES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .first_block(first_block), .last_block(last_block),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .mapped(mapped), .ranges_held(ranges_held)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls with a chance of about 13 in 100, never while calm
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 13);
	end

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("tb: mismatch %s got %0d expected %0d (beat %0d)", what, got, want,
			beats_checked);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result beat", status, 0);
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (mapped !== want.mp)
					report_mismatch("mapped", mapped, want.mp);
				if (ranges_held !== want.cnt)
					report_mismatch("ranges_held", ranges_held, want.cnt);
				beats_checked++;
			end
		end
	end

	// predictor pieces
	function automatic void wipe_table();
		tbl_count = 0;
		tbl_done = 1'b0;
	endfunction

	function automatic status_t finish_table();
		logic [63:0] kf;
		logic [63:0] kl;
		int j;
		// insertion sort by first block
		for (int i = 1; i < tbl_count; i++) begin
			kf = tbl_first[i];
			kl = tbl_last[i];
			j = i;
			while (j > 0 && tbl_first[j-1] > kf) begin
				tbl_first[j] = tbl_first[j-1];
				tbl_last[j] = tbl_last[j-1];
				j--;
			end
			tbl_first[j] = kf;
			tbl_last[j] = kl;
		end
		for (int i = 1; i < tbl_count; i++)
			if (tbl_first[i] <= tbl_last[i-1]) begin
				wipe_table();
				return ST_OVERLAP;
			end
		for (int i = 0; i < tbl_count; i++)
			if (tbl_first[i] > MAX32 || tbl_last[i] > MAX32) begin
				wipe_table();
				return ST_PAST_32;
			end
		tbl_done = 1'b1;
		return ST_OK;
	endfunction

	function automatic logic block_is_mapped(logic [63:0] blk);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (blk < tbl_first[mid])
				hi = mid;
			else
				lo = mid + 1;
		end
		if (lo == 0)
			return 1'b0;
		return blk <= tbl_last[lo-1];
	endfunction

	function automatic answer_t predict_answer(cmd_t c, logic [63:0] a, logic [63:0] b);
		answer_t r;
		r.st = ST_OK;
		r.mp = 1'b0;
		case (c)
			CMD_CLEAR: wipe_table();
			CMD_ADD: begin
				if (a > b || b == ALL_ONES) begin
					wipe_table();
					r.st = ST_BAD_RANGE;
				end else if (tbl_count >= MAX_RANGES) begin
					r.st = ST_FULL;
				end else begin
					tbl_first[tbl_count] = a;
					tbl_last[tbl_count] = b;
					tbl_count++;
					tbl_done = 1'b0;
				end
			end
			CMD_FINISH: r.st = finish_table();
			default: begin
				if (!tbl_done)
					r.st = ST_NOT_FINISHED;
				else
					r.mp = block_is_mapped(a);
				if (r.mp)
					queries_hit++;
			end
		endcase
		r.cnt = tbl_count[10:0];
		return r;
	endfunction

	// send one beat; valid is only lowered when an idle gap is taken
	task automatic send_item(cmd_t c, logic [63:0] a, logic [63:0] b);
		if (!calm && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 13)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		first_block <= a;
		last_block <= b;
		do
			@(posedge clk);
		while (!in_ready);
		pending_answers.insert(pending_answers.size(), predict_answer(c, a, b));
		beats_sent++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// wait until every result is in, then settle before the next phase
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// extremes of the fields and every special case but a full table
	task automatic test_directed();
		send_item(CMD_QUERY, 64'd7, 64'd0);                  // query before finish
		send_item(CMD_FINISH, ALL_ONES, ALL_ONES);           // finish empty table
		send_item(CMD_QUERY, 64'd0, ALL_ONES);               // empty table maps nothing
		send_item(CMD_ADD, 64'd10, 64'd5);                   // first above last
		send_item(CMD_ADD, 64'd3, ALL_ONES);                 // end wraps
		send_item(CMD_ADD, 64'd0, 64'd0);
		send_item(CMD_ADD, MAX32, MAX32);
		send_item(CMD_ADD, 64'd5, 64'd10);
		send_item(CMD_FINISH, 64'd0, 64'd0);
		send_item(CMD_FINISH, 64'd0, 64'd0);                 // finish again
		send_item(CMD_QUERY, 64'd0, 64'd0);
		send_item(CMD_QUERY, 64'd4, 64'd0);
		send_item(CMD_QUERY, 64'd5, 64'd0);
		send_item(CMD_QUERY, 64'd10, 64'd0);
		send_item(CMD_QUERY, 64'd11, 64'd0);
		send_item(CMD_QUERY, MAX32, 64'd0);
		send_item(CMD_QUERY, ALL_ONES, 64'd0);
		send_item(CMD_ADD, 64'd8, 64'd20);                   // overlaps 5..10
		send_item(CMD_FINISH, 64'd0, 64'd0);
		send_item(CMD_ADD, 64'd1, 64'd2);
		send_item(CMD_ADD, ALL_ONES - 1, ALL_ONES - 1);      // past 32-bit
		send_item(CMD_FINISH, 64'd0, 64'd0);
		send_item(CMD_ADD, 64'd1, 64'd2);
		send_item(CMD_CLEAR, ALL_ONES, ALL_ONES);
		drain();
	endtask

	// fill the table, overflow it, query it, then a bad add clears it
	task automatic test_full_table();
		calm = 1'b1;
		send_item(CMD_CLEAR, 64'd0, 64'd0);
		// ascending order keeps the sort short on a full table
		for (int i = 0; i < MAX_RANGES; i++)
			send_item(CMD_ADD, 64'(4 * i), 64'(4 * i + 1));
		calm = 1'b0;
		send_item(CMD_ADD, 64'd9000, 64'd9001);              // table full
		send_item(CMD_FINISH, 64'd0, 64'd0);
		for (int i = 0; i < 12; i++)
			send_item(CMD_QUERY, 64'($urandom_range(4 * MAX_RANGES + 4)), 64'd0);
		send_item(CMD_QUERY, 64'(4 * MAX_RANGES - 3), 64'd0);
		send_item(CMD_ADD, 64'd9000, 64'd9001);              // still full
		send_item(CMD_ADD, 64'd2, 64'd1);                    // bad range clears
		drain();
	endtask

	// one build, finish and query sequence with random content and an occasional flaw
	task automatic run_sequence();
		logic [63:0] rf [16];
		logic [63:0] rl [16];
		logic [63:0] cur;
		logic [63:0] tf;
		logic [63:0] tl;
		int n;
		int k;
		int flaw;
		n = $urandom_range(15, 1);
		flaw = $urandom_range(9);
		cur = ($urandom_range(3) == 0) ? 64'(32'hFFF0_0000 + $urandom_range(65535)) :
			64'($urandom_range(200));
		for (int i = 0; i < n; i++) begin
			rf[i] = cur;
			rl[i] = cur + $urandom_range(($urandom_range(1)) ? 3 : 100000);
			cur = rl[i] + 1 + $urandom_range(($urandom_range(1)) ? 2 : 1000000);
			if (rl[i] > MAX32 && flaw != 1) begin
				n = i;
				break;
			end
		end
		if (flaw == 0 && n > 1)
			rf[n-1] = rl[n-2] - $urandom_range(1);          // overlap
		if (flaw == 1 && n > 0)
			rl[n-1] = rl[n-1] | 64'h1_0000_0000;             // past 32-bit
		for (int i = n - 1; i > 0; i--) begin
			k = $urandom_range(i);
			tf = rf[i]; rf[i] = rf[k]; rf[k] = tf;
			tl = rl[i]; rl[i] = rl[k]; rl[k] = tl;
		end
		send_item(CMD_CLEAR, rand64(), rand64());
		for (int i = 0; i < n; i++)
			send_item(CMD_ADD, rf[i], rl[i]);
		if (flaw == 2)
			send_item(CMD_ADD, rand64() | 64'd1, 64'd0);     // bad range mid build
		send_item(CMD_FINISH, rand64(), rand64());
		for (int q = $urandom_range(8, 2); q > 0; q--) begin
			k = (n > 0) ? $urandom_range(n - 1) : 0;
			case ($urandom_range(4))
				0: tf = rf[k];
				1: tf = rl[k];
				2: tf = rl[k] + 1;
				3: tf = rf[k] - 1;
				default: tf = rand64() >> $urandom_range(63);
			endcase
			send_item(CMD_QUERY, tf, rand64());
		end
	endtask

	task automatic test_random();
		int start;
		start = beats_sent;
		while (beats_sent - start < 550) begin
			if ($urandom_range(9) < 8) begin
				run_sequence();
			end else begin
				for (int i = $urandom_range(4, 1); i > 0; i--)
					send_item(cmd_t'($urandom_range(3)), rand64(), rand64());
			end
			// a stretch with no idling on either side
			calm = (beats_sent - start > 200 && beats_sent - start < 350);
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_CLEAR;
		first_block = '0;
		last_block = '0;
		calm = 1'b0;
		errors = 0;
		beats_sent = 0;
		beats_checked = 0;
		queries_hit = 0;
		cycles = 0;
		wipe_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_table();
		test_random();

		$display("tb: %0d beats sent, %0d results checked, %0d queries mapped",
			beats_sent, beats_checked, queries_hit);
		$display("tb: covered clear, add, full table, finish with overlap and past 32-bit");
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches, %0d results missing", errors,
				pending_answers.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule
